// ----- rtl/ipfd_pkg.sv -----
package ipfd_pkg;

   localparam int LONG_BITS_DEF  = 24;
   localparam int SHORT_BITS_DEF = 14;
   localparam int TICK_WIDTH_DEF = 12;

   localparam int CFG_W     = 12;
   localparam int PAYLOAD_W = 24;
   localparam int COUNT_W   = 5;
   localparam int CNT_W     = 6;
   localparam int LEN_W     = 8;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SPACE,
      PH_MARK
   } phase_type;

   typedef enum logic [2:0] {
      REG_HEADER_MIN,
      REG_HEADER_MAX,
      REG_GAP_MIN,
      REG_GAP_MAX,
      REG_ONE_MIN,
      REG_ONE_MAX,
      REG_ZERO_MIN,
      REG_ZERO_MAX
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] header_min;
      logic [CFG_W-1:0] header_max;
      logic [CFG_W-1:0] gap_min;
      logic [CFG_W-1:0] gap_max;
      logic [CFG_W-1:0] one_min;
      logic [CFG_W-1:0] one_max;
      logic [CFG_W-1:0] zero_min;
      logic [CFG_W-1:0] zero_max;
   } windows_type;

   localparam logic [CFG_W-1:0] HEADER_MIN_RST = CFG_W'(36);
   localparam logic [CFG_W-1:0] HEADER_MAX_RST = CFG_W'(62);
   localparam logic [CFG_W-1:0] GAP_MIN_RST    = CFG_W'(8);
   localparam logic [CFG_W-1:0] GAP_MAX_RST    = CFG_W'(17);
   localparam logic [CFG_W-1:0] ONE_MIN_RST    = CFG_W'(18);
   localparam logic [CFG_W-1:0] ONE_MAX_RST    = CFG_W'(32);
   localparam logic [CFG_W-1:0] ZERO_MIN_RST   = CFG_W'(8);
   localparam logic [CFG_W-1:0] ZERO_MAX_RST   = CFG_W'(17);

endpackage

// ----- rtl/ipfd_csr.sv -----
module ipfd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ipfd_pkg::ADDR_W-1:0] paddr,
   input  logic [ipfd_pkg::DATA_W-1:0] pwdata,
   output logic [ipfd_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output ipfd_pkg::windows_type       windows
);
   import ipfd_pkg::*;

   windows_type   win_ff;
   windows_type   win_in;
   reg_index_type reg_sel;
   logic          wr_en;
   logic [CFG_W-1:0] wr_val;
   logic [CFG_W-1:0] rd_val;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign wr_val  = pwdata[CFG_W-1:0];

   always_comb begin
      win_in = win_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_HEADER_MIN: win_in.header_min = wr_val;
            REG_HEADER_MAX: win_in.header_max = wr_val;
            REG_GAP_MIN:    win_in.gap_min    = wr_val;
            REG_GAP_MAX:    win_in.gap_max    = wr_val;
            REG_ONE_MIN:    win_in.one_min    = wr_val;
            REG_ONE_MAX:    win_in.one_max    = wr_val;
            REG_ZERO_MIN:   win_in.zero_min   = wr_val;
            REG_ZERO_MAX:   win_in.zero_max   = wr_val;
            default:        win_in = win_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_HEADER_MIN: rd_val = win_ff.header_min;
         REG_HEADER_MAX: rd_val = win_ff.header_max;
         REG_GAP_MIN:    rd_val = win_ff.gap_min;
         REG_GAP_MAX:    rd_val = win_ff.gap_max;
         REG_ONE_MIN:    rd_val = win_ff.one_min;
         REG_ONE_MAX:    rd_val = win_ff.one_max;
         REG_ZERO_MIN:   rd_val = win_ff.zero_min;
         REG_ZERO_MAX:   rd_val = win_ff.zero_max;
         default:        rd_val = '0;
      endcase
   end

   assign prdata  = DATA_W'(rd_val);
   assign windows = win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.header_min <= HEADER_MIN_RST;
         win_ff.header_max <= HEADER_MAX_RST;
         win_ff.gap_min    <= GAP_MIN_RST;
         win_ff.gap_max    <= GAP_MAX_RST;
         win_ff.one_min    <= ONE_MIN_RST;
         win_ff.one_max    <= ONE_MAX_RST;
         win_ff.zero_min   <= ZERO_MIN_RST;
         win_ff.zero_max   <= ZERO_MAX_RST;
      end else begin
         win_ff <= win_in;
      end
   end

endmodule

// ----- rtl/ipfd_decode.sv -----
module ipfd_decode #(
   parameter int LONG_BITS  = ipfd_pkg::LONG_BITS_DEF,
   parameter int SHORT_BITS = ipfd_pkg::SHORT_BITS_DEF,
   parameter int TICK_WIDTH = ipfd_pkg::TICK_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   input  logic [TICK_WIDTH-1:0]          duration,
   input  logic                           frame_start,
   input  logic [ipfd_pkg::LEN_W-1:0]     capture_length,
   input  ipfd_pkg::windows_type          windows,
   output logic                           res_valid,
   output logic                           res_status,
   output logic [ipfd_pkg::PAYLOAD_W-1:0] res_payload,
   output logic [ipfd_pkg::COUNT_W-1:0]   res_bit_count
);
   import ipfd_pkg::*;

   localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
   localparam logic [LEN_W-1:0] LONG_LEN   = LEN_W'(2 * LONG_BITS);
   localparam logic [LEN_W-1:0] SHORT_LEN  = LEN_W'(2 * SHORT_BITS);
   localparam logic [LEN_W-1:0] LONG_NEED  = LEN_W'(2 * LONG_BITS + 2);
   localparam logic [LEN_W-1:0] SHORT_NEED = LEN_W'(2 * SHORT_BITS + 2);
   localparam logic [CNT_W-1:0] LONG_CNT   = CNT_W'(LONG_BITS);
   localparam logic [CNT_W-1:0] SHORT_CNT  = CNT_W'(SHORT_BITS);

   phase_type            phase_ff, phase_in;
   logic [CNT_W-1:0]     bit_idx_ff, bit_idx_in;
   logic [CNT_W-1:0]     target_ff, target_in;
   logic [PAYLOAD_W-1:0] shift_ff, shift_in;

   logic [CMP_W-1:0]     dur;
   logic                 hdr_hit, gap_hit, one_hit, zero_hit;
   logic                 start_err;
   logic [CNT_W-1:0]     start_target;
   logic [CNT_W-1:0]     bit_next;
   logic                 bit_done;
   logic [PAYLOAD_W-1:0] shift_set;

   function automatic logic in_window(logic [CMP_W-1:0] d, logic [CFG_W-1:0] lo,
                                      logic [CFG_W-1:0] hi);
      return (d >= CMP_W'(lo)) && (d <= CMP_W'(hi));
   endfunction

   assign dur      = CMP_W'(duration);
   assign hdr_hit  = in_window(dur, windows.header_min, windows.header_max);
   assign gap_hit  = in_window(dur, windows.gap_min, windows.gap_max);
   assign one_hit  = in_window(dur, windows.one_min, windows.one_max);
   assign zero_hit = in_window(dur, windows.zero_min, windows.zero_max);

   always_comb begin
      if (capture_length >= LONG_LEN) begin
         start_target = LONG_CNT;
         start_err    = capture_length < LONG_NEED;
      end else if (capture_length >= SHORT_LEN) begin
         start_target = SHORT_CNT;
         start_err    = capture_length < SHORT_NEED;
      end else begin
         start_target = '0;
         start_err    = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < PAYLOAD_W; i++) begin
         shift_set[i] = one_hit && (bit_idx_ff == CNT_W'(i));
      end
   end

   assign bit_next = bit_idx_ff + CNT_W'(1);
   assign bit_done = bit_next >= target_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (item_valid) begin
         if (frame_start) begin
            phase_in = start_err ? PH_IDLE : PH_HEADER;
         end else begin
            case (phase_ff)
               PH_IDLE:   phase_in = PH_IDLE;
               PH_HEADER: phase_in = hdr_hit ? PH_SPACE : PH_IDLE;
               PH_SPACE:  phase_in = gap_hit ? PH_MARK : PH_IDLE;
               PH_MARK:   phase_in = ((one_hit || zero_hit) && !bit_done) ? PH_SPACE : PH_IDLE;
               default:   phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // results and datapath
   always_comb begin
      res_valid     = 1'b0;
      res_status    = 1'b1;
      res_payload   = '0;
      res_bit_count = '0;
      bit_idx_in    = bit_idx_ff;
      target_in     = target_ff;
      shift_in      = shift_ff;
      if (item_valid) begin
         if (frame_start) begin
            bit_idx_in = '0;
            target_in  = start_target;
            shift_in   = '0;
            res_valid  = start_err;
         end else begin
            case (phase_ff)
               PH_HEADER: res_valid = !hdr_hit;
               PH_SPACE:  res_valid = !gap_hit;
               PH_MARK: begin
                  if (!one_hit && !zero_hit) begin
                     res_valid = 1'b1;
                  end else begin
                     shift_in   = shift_ff | shift_set;
                     bit_idx_in = bit_next;
                     if (bit_done) begin
                        res_valid     = 1'b1;
                        res_status    = 1'b0;
                        res_payload   = shift_ff | shift_set;
                        res_bit_count = target_ff[COUNT_W-1:0];
                     end
                  end
               end
               default: res_valid = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_idx_ff <= '0;
         target_ff  <= '0;
         shift_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         bit_idx_ff <= bit_idx_in;
         target_ff  <= target_in;
         shift_ff   <= shift_in;
      end
   end

endmodule

// ----- rtl/ir_pulse_width_frame_decoder.sv -----
// Decodes one IR frame from its captured pulse durations, one capture entry per
// beat. The beat flagged frame_start is the leading gap; its capture_length
// picks LONG_BITS or SHORT_BITS data bits, or rejects the frame at once when the
// capture is too short. Then come a header mark and, per bit, a space and a
// mark, each checked against the windows in the eight 12-bit registers at byte
// addresses 0x00..0x1C; a mark in both bit windows reads as one. One result
// follows per frame: status 0 with the bits first-received-in-bit-zero and the
// bit count, or status 1 with payload and count zero. A new frame_start drops a
// frame in progress without a result. The block takes one entry every cycle
// unless the result register stalls; the entry that ends the frame passes the
// input register, then the result register behind the combinational window
// compare and shift, and only a stalled result register holds up the input.
module ir_pulse_width_frame_decoder #(
   parameter int LONG_BITS  = ipfd_pkg::LONG_BITS_DEF,
   parameter int SHORT_BITS = ipfd_pkg::SHORT_BITS_DEF,
   parameter int TICK_WIDTH = ipfd_pkg::TICK_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [TICK_WIDTH-1:0]          req_duration,
   input  logic                           req_frame_start,
   input  logic [ipfd_pkg::LEN_W-1:0]     req_capture_length,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_status,
   output logic [ipfd_pkg::PAYLOAD_W-1:0] rsp_payload,
   output logic [ipfd_pkg::COUNT_W-1:0]   rsp_bit_count,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ipfd_pkg::ADDR_W-1:0]    paddr,
   input  logic [ipfd_pkg::DATA_W-1:0]    pwdata,
   output logic [ipfd_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);
   import ipfd_pkg::*;

   windows_type          windows;

   logic                 stg_valid_ff, stg_valid_in;
   logic [TICK_WIDTH-1:0] stg_duration_ff;
   logic                 stg_start_ff;
   logic [LEN_W-1:0]     stg_len_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff;
   logic [PAYLOAD_W-1:0] rsp_payload_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 advance;
   logic                 req_take;
   logic                 res_valid;
   logic                 res_status;
   logic [PAYLOAD_W-1:0] res_payload;
   logic [COUNT_W-1:0]   res_bit_count;

   ipfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .windows (windows)
   );

   ipfd_decode #(
      .LONG_BITS  (LONG_BITS),
      .SHORT_BITS (SHORT_BITS),
      .TICK_WIDTH (TICK_WIDTH)
   ) u_decode (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (stg_valid_ff && advance),
      .duration       (stg_duration_ff),
      .frame_start    (stg_start_ff),
      .capture_length (stg_len_ff),
      .windows        (windows),
      .res_valid      (res_valid),
      .res_status     (res_status),
      .res_payload    (res_payload),
      .res_bit_count  (res_bit_count)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !stg_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
      rsp_valid_in = advance ? (stg_valid_ff && res_valid) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the beat until the decode stage can take it
   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_duration_ff <= req_duration;
         stg_start_ff    <= req_frame_start;
         stg_len_ff      <= req_capture_length;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff  <= res_status;
         rsp_payload_ff <= res_payload;
         rsp_count_ff   <= res_bit_count;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_payload   = rsp_payload_ff;
   assign rsp_bit_count = rsp_count_ff;

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_payload == '0 && rsp_bit_count == '0)
      else $error("rejected frame carries data");

   a_good_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |->
         rsp_bit_count == COUNT_W'(LONG_BITS) || rsp_bit_count == COUNT_W'(SHORT_BITS))
      else $error("decoded frame has unexpected bit count");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stg_valid_ff))
      else $error("result without an entry in the decode stage");

endmodule

// ----- test/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ipfd_pkg::*;

   localparam int TW = TICK_WIDTH_DEF;
   localparam logic ST_OK = 1'b0;
   localparam logic ST_ERR = 1'b1;
   localparam int TAIL_CYCLES = 6;
   localparam int TOTAL_BEATS = 1950;
   localparam int PHASE_BEATS = 150;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic                 status;
      logic [PAYLOAD_W-1:0] payload;
      logic [COUNT_W-1:0]   bit_count;
   } frame_result_type;

   typedef struct packed {
      logic [TW-1:0]    dur;
      logic             start;
      logic [LEN_W-1:0] len;
      logic             err;
   } probe_row_type;

   typedef enum int {
      WIN_RESET,
      WIN_OPEN,
      WIN_ZERO,
      WIN_TOP,
      WIN_RANDOM,
      WIN_OVERLAP,
      WIN_NO_ONE,
      WIN_NO_HEADER
   } window_plan_type;

   localparam frame_result_type REJECT = '{status: ST_ERR, payload: '0, bit_count: '0};

   localparam logic [TW-1:0] RST_WIN [8] = '{
      HEADER_MIN_RST, HEADER_MAX_RST, GAP_MIN_RST, GAP_MAX_RST,
      ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST
   };

   localparam window_plan_type PLAN_SEQ [7] = '{
      WIN_OPEN, WIN_ZERO, WIN_TOP, WIN_NO_ONE, WIN_OVERLAP, WIN_NO_HEADER, WIN_RESET
   };

   // duration, frame_start, capture_length, rejected at once
   localparam probe_row_type PROBES [33] = '{
      '{12'd0,    1'b0, 8'd0,   1'b0},
      '{12'd4095, 1'b0, 8'd255, 1'b0},
      '{12'd4095, 1'b1, 8'd0,   1'b1},
      '{12'd0,    1'b1, 8'd27,  1'b1},
      '{12'd0,    1'b1, 8'd28,  1'b1},
      '{12'd0,    1'b1, 8'd29,  1'b1},
      '{12'd0,    1'b1, 8'd48,  1'b1},
      '{12'd0,    1'b1, 8'd49,  1'b1},
      '{12'd4095, 1'b1, 8'd30,  1'b0},
      '{12'd35,   1'b0, 8'd0,   1'b1},
      '{12'd0,    1'b1, 8'd50,  1'b0},
      '{12'd36,   1'b0, 8'd0,   1'b0},
      '{12'd7,    1'b0, 8'd0,   1'b1},
      '{12'd0,    1'b1, 8'd255, 1'b0},
      '{12'd62,   1'b0, 8'd0,   1'b0},
      '{12'd8,    1'b0, 8'd0,   1'b0},
      '{12'd33,   1'b0, 8'd0,   1'b1},
      '{12'd0,    1'b1, 8'd30,  1'b0},
      '{12'd63,   1'b0, 8'd0,   1'b1},
      '{12'd0,    1'b1, 8'd30,  1'b0},
      '{12'd40,   1'b0, 8'd0,   1'b0},
      '{12'd17,   1'b0, 8'd0,   1'b0},
      '{12'd32,   1'b0, 8'd0,   1'b0},
      '{12'd18,   1'b0, 8'd0,   1'b1},
      '{12'd0,    1'b1, 8'd47,  1'b0},
      '{12'd50,   1'b0, 8'd0,   1'b0},
      '{12'd12,   1'b0, 8'd0,   1'b0},
      '{12'd7,    1'b0, 8'd0,   1'b1},
      '{12'd0,    1'b1, 8'd200, 1'b0},
      '{12'd45,   1'b0, 8'd0,   1'b0},
      '{12'd0,    1'b1, 8'd30,  1'b0},
      '{12'd4095, 1'b0, 8'd0,   1'b1},
      '{12'd18,   1'b0, 8'd0,   1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [TW-1:0]        req_duration = '0;
   logic                 req_frame_start = 1'b0;
   logic [LEN_W-1:0]     req_capture_length = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_status;
   logic [PAYLOAD_W-1:0] rsp_payload;
   logic [COUNT_W-1:0]   rsp_bit_count;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_W-1:0]    paddr = '0;
   logic [DATA_W-1:0]    pwdata = '0;
   logic [DATA_W-1:0]    prdata;
   logic                 pready;

   logic [TW-1:0]        win_reg [8];
   phase_type            dec_phase = PH_IDLE;
   int                   dec_bits = 0;
   int                   dec_index = 0;
   logic [PAYLOAD_W-1:0] dec_shift = '0;

   frame_result_type     pending [$];
   frame_result_type     want;
   int                   mismatches = 0;
   int                   fed = 0;
   int                   hold = 0;
   bit                   tx_calm = 1'b0;
   bit                   rx_calm = 1'b0;
   longint               cycles = 0;

   ir_pulse_width_frame_decoder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_duration       (req_duration),
      .req_frame_start    (req_frame_start),
      .req_capture_length (req_capture_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload        (rsp_payload),
      .rsp_bit_count      (rsp_bit_count),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic flag_mismatch(string what);
      if (mismatches < 100) $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(99);
      if (calm || r < 60) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic bit fits(logic [TW-1:0] d, reg_index_type lo);
      return d >= win_reg[lo] && d <= win_reg[lo + 1];
   endfunction

   function automatic logic [TW-1:0] pick_in(reg_index_type lo);
      int r;
      r = $urandom_range(3);
      if (win_reg[lo] > win_reg[lo + 1]) return TW'($urandom_range(4095));
      if (r == 0) return win_reg[lo];
      if (r == 1) return win_reg[lo + 1];
      return TW'($urandom_range(win_reg[lo + 1], win_reg[lo]));
   endfunction

   task automatic decode_entry(input logic [TW-1:0] d, input logic s, input logic [LEN_W-1:0] l,
                               output bit got, output frame_result_type res);
      bit bad;
      bad = 1'b0;
      got = 1'b0;
      res = '0;
      if (s) begin
         dec_index = 0;
         dec_shift = '0;
         dec_phase = PH_HEADER;
         if (l >= 2 * LONG_BITS_DEF) dec_bits = LONG_BITS_DEF;
         else if (l >= 2 * SHORT_BITS_DEF) dec_bits = SHORT_BITS_DEF;
         else dec_bits = 0;
         bad = dec_bits == 0 || l < 2 * dec_bits + 2;
      end else begin
         case (dec_phase)
            PH_HEADER: begin
               if (fits(d, REG_HEADER_MIN)) dec_phase = PH_SPACE;
               else bad = 1'b1;
            end
            PH_SPACE: begin
               if (fits(d, REG_GAP_MIN)) dec_phase = PH_MARK;
               else bad = 1'b1;
            end
            PH_MARK: begin
               if (fits(d, REG_ONE_MIN)) dec_shift[dec_index] = 1'b1;
               else if (!fits(d, REG_ZERO_MIN)) bad = 1'b1;
               if (!bad) begin
                  dec_index++;
                  dec_phase = PH_SPACE;
                  if (dec_index >= dec_bits) begin
                     got = 1'b1;
                     res = '{status: ST_OK, payload: dec_shift, bit_count: COUNT_W'(dec_bits)};
                     dec_phase = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
      if (bad) begin
         got = 1'b1;
         res = REJECT;
         dec_phase = PH_IDLE;
      end
   endtask

   task automatic send_entry(logic [TW-1:0] d, logic s, logic [LEN_W-1:0] l, logic err);
      int n;
      bit got;
      frame_result_type res;
      n = pick_gap(tx_calm);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_duration <= d;
      req_frame_start <= s;
      req_capture_length <= l;
      do @(posedge clock); while (!req_ready);
      if (s || dec_phase != PH_IDLE) fed++;
      decode_entry(d, s, l, got, res);
      if (err) pending.push_back(REJECT);
      else if (got) pending.push_back(res);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [TW-1:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(4 * int'(idx));
      pwdata <= {20'($urandom), v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      win_reg[idx] = v;
   endtask

   task automatic csr_read(reg_index_type idx, output logic [DATA_W-1:0] rd);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_W'(4 * int'(idx));
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_windows(window_plan_type plan);
      logic [TW-1:0] v [8];
      logic [DATA_W-1:0] rd;
      int a;
      int lo;
      int hi;
      v = RST_WIN;
      case (plan)
         WIN_OPEN: for (int i = 0; i < 8; i++) v[i] = (i % 2) ? 12'd4095 : 12'd0;
         WIN_ZERO: for (int i = 0; i < 8; i++) v[i] = 12'd0;
         WIN_TOP: for (int i = 0; i < 8; i++) v[i] = 12'd4095;
         WIN_OVERLAP: begin
            a = $urandom_range(3000);
            v[REG_ZERO_MIN] = TW'(a);
            v[REG_ZERO_MAX] = TW'(a + 200);
            v[REG_ONE_MIN] = TW'(a + 100);
            v[REG_ONE_MAX] = TW'(a + 400);
         end
         WIN_NO_ONE: begin
            v[REG_ONE_MIN] = 12'd4095;
            v[REG_ONE_MAX] = 12'd0;
         end
         WIN_NO_HEADER: begin
            v[REG_HEADER_MIN] = 12'd4095;
            v[REG_HEADER_MAX] = 12'd0;
         end
         WIN_RANDOM: begin
            for (int i = 0; i < 8; i += 2) begin
               lo = $urandom_range(4095);
               hi = lo + $urandom_range(150);
               if (hi > 4095) hi = 4095;
               if ($urandom_range(99) < 10) begin
                  v[i] = TW'(hi);
                  v[i + 1] = TW'(lo);
               end else begin
                  v[i] = TW'(lo);
                  v[i + 1] = TW'(hi);
               end
            end
         end
         default: ;
      endcase
      drain();
      for (int i = 0; i < 8; i++) csr_write(reg_index_type'(i), v[i]);
      for (int i = 0; i < 8; i++) begin
         csr_read(reg_index_type'(i), rd);
         if (rd !== DATA_W'(v[i]))
            flag_mismatch($sformatf("register %0d reads %0h, want %0h", i, rd, v[i]));
      end
   endtask

   task automatic send_frame();
      int r;
      int nbits;
      int cut;
      int noise_pct;
      logic [LEN_W-1:0] len;
      logic [TW-1:0] d;
      r = $urandom_range(99);
      tx_calm = $urandom_range(99) < 15;
      noise_pct = ($urandom_range(99) < 60) ? 0 : $urandom_range(6, 1);
      if (r < 8) begin
         case ($urandom_range(3))
            0: len = LEN_W'($urandom_range(27));
            1: len = LEN_W'(28 + $urandom_range(1));
            2: len = LEN_W'(48 + $urandom_range(1));
            default: len = LEN_W'($urandom_range(255));
         endcase
         send_entry(TW'($urandom_range(4095)), 1'b1, len, 1'b0);
         return;
      end
      if (r < 55) begin
         len = LEN_W'($urandom_range(255, 50));
         nbits = LONG_BITS_DEF;
      end else begin
         len = LEN_W'($urandom_range(47, 30));
         nbits = SHORT_BITS_DEF;
      end
      cut = ($urandom_range(99) < 6) ? $urandom_range(2 * nbits) : -1;
      send_entry(TW'($urandom_range(4095)), 1'b1, len, 1'b0);
      for (int i = 0; i <= 2 * nbits; i++) begin
         // drop the rest of a frame that is already over, or cut it short for a restart
         if (i == cut) return;
         if (dec_phase == PH_IDLE && $urandom_range(99) < 85) return;
         if (noise_pct > 0 && $urandom_range(99) < noise_pct) d = TW'($urandom_range(4095));
         else if (i == 0) d = pick_in(REG_HEADER_MIN);
         else if (i % 2) d = pick_in(REG_GAP_MIN);
         else if ($urandom_range(1) && win_reg[REG_ONE_MIN] <= win_reg[REG_ONE_MAX])
            d = pick_in(REG_ONE_MIN);
         else d = pick_in(REG_ZERO_MIN);
         send_entry(d, 1'b0, LEN_W'($urandom_range(255)), 1'b0);
      end
      if ($urandom_range(99) < 15)
         repeat ($urandom_range(3, 1))
            send_entry(TW'($urandom_range(4095)), 1'b0, LEN_W'($urandom_range(255)), 1'b0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending.size() == 0) begin
               flag_mismatch("result beat with nothing pending");
            end else begin
               want = pending.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_payload !== want.payload)
                  flag_mismatch($sformatf("payload %06h, want %06h", rsp_payload, want.payload));
               if (rsp_bit_count !== want.bit_count)
                  flag_mismatch($sformatf("bit_count %0d, want %0d", rsp_bit_count,
                                          want.bit_count));
            end
         end
         if ($urandom_range(255) == 0) rx_calm = !rx_calm;
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!rx_calm && $urandom_range(99) < 30) hold = pick_gap(1'b0);
         end
      end
   end

   initial begin
      int p;
      int mark;
      win_reg = RST_WIN;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < $size(PROBES); i++)
         send_entry(PROBES[i].dur, PROBES[i].start, PROBES[i].len, PROBES[i].err);
      p = 0;
      while (fed < TOTAL_BEATS) begin
         load_windows(p < $size(PLAN_SEQ) ? PLAN_SEQ[p] : WIN_RANDOM);
         mark = fed;
         while (fed - mark < PHASE_BEATS && fed < TOTAL_BEATS) begin
            if ($urandom_range(99) < 3) drain();
            send_frame();
         end
         p++;
      end
      drain();
      if (mismatches == 0 && pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ipfd_pkg.sv
rtl/ipfd_csr.sv
rtl/ipfd_decode.sv
rtl/ir_pulse_width_frame_decoder.sv
test/tb.sv
